// File: design/dnsrp_pkg.sv
// Package: parser phase codes, status codes and the parser state type for the DNS reply parser.
package dnsrp_pkg;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QNAME  = 4'd1;
  localparam logic [3:0] PH_QLABEL = 4'd2;
  localparam logic [3:0] PH_QTAIL  = 4'd3;
  localparam logic [3:0] PH_ANAME  = 4'd4;
  localparam logic [3:0] PH_ALABEL = 4'd5;
  localparam logic [3:0] PH_APTR   = 4'd6;
  localparam logic [3:0] PH_RHDR   = 4'd7;
  localparam logic [3:0] PH_ADATA  = 4'd8;
  localparam logic [3:0] PH_RDATA  = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_SRVERR  = 3'd1;
  localparam logic [2:0] ST_NOANS   = 3'd2;
  localparam logic [2:0] ST_RESOLVED = 3'd3;
  localparam logic [2:0] ST_NOADDR  = 3'd4;

  localparam logic [7:0]  PTR_MASK     = 8'hC0;
  localparam logic [15:0] RR_FIXED_LEN = 16'd10;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [3:0]  HDR_LEN      = 4'd12;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  offset;     // bytes seen, saturating at the header length
    logic        qr;
    logic        rcode_nz;
    logic [15:0] ans_total;
    logic [15:0] ans_done;
    logic [15:0] skip;
    logic [15:0] rtype;
    logic [7:0]  rlen_hi;
    logic [31:0] addr;
    logic        found;
  } st_t;

endpackage

// File: design/dnsrp_if.sv
// Interfaces: byte input channel and result channel of the DNS reply parser.
interface dnsrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] address;
  modport source (output valid, output status, output address, input ready);
  modport sink (input valid, input status, input address, output ready);
endinterface

// File: design/dnsrp_parse.sv
// Next-state and status logic of the DNS reply parser for one byte.
module dnsrp_parse (
  input  dnsrp_pkg::st_t st,
  input  logic [7:0]     data_byte,
  output dnsrp_pkg::st_t nxt,
  output logic [2:0]     status,
  output logic [31:0]    address
);
  import dnsrp_pkg::*;

  logic [15:0] skip_dec;
  logic [15:0] done_inc;
  logic [15:0] len_now;
  logic        is_ptr;

  assign skip_dec = st.skip - 16'd1;
  assign done_inc = st.ans_done + 16'd1;
  assign len_now  = {st.rlen_hi, data_byte};
  assign is_ptr   = (data_byte & PTR_MASK) == PTR_MASK;

  always_comb begin
    nxt = st;
    if (st.offset != HDR_LEN) begin
      nxt.offset = st.offset + 4'd1;
    end
    unique case (st.phase)
      PH_HEADER: begin
        unique case (st.offset)
          4'd2:  nxt.qr = data_byte[7];
          4'd3:  nxt.rcode_nz = data_byte[3:0] != 4'd0;
          4'd6:  nxt.ans_total = {data_byte, 8'h00};
          4'd7:  nxt.ans_total = {st.ans_total[15:8], data_byte};
          4'd11: begin
            if (!st.qr || st.rcode_nz || st.ans_total == 16'd0) nxt.phase = PH_DONE;
            else nxt.phase = PH_QNAME;
          end
          default: ;
        endcase
      end
      PH_QNAME: begin
        if (data_byte == 8'd0) begin
          nxt.phase = PH_QTAIL;
          nxt.skip  = 16'd4;
        end else if (is_ptr) begin
          nxt.phase = PH_QTAIL;
          nxt.skip  = 16'd5;
        end else begin
          nxt.phase = PH_QLABEL;
          nxt.skip  = {8'h00, data_byte};
        end
      end
      PH_QLABEL: begin
        nxt.skip = skip_dec;
        if (skip_dec == 16'd0) nxt.phase = PH_QNAME;
      end
      PH_QTAIL: begin
        nxt.skip = skip_dec;
        if (skip_dec == 16'd0) nxt.phase = PH_ANAME;
      end
      PH_ANAME: begin
        if (data_byte == 8'd0) begin
          nxt.phase = PH_RHDR;
          nxt.skip  = RR_FIXED_LEN;
        end else if (is_ptr) begin
          nxt.phase = PH_APTR;
        end else begin
          nxt.phase = PH_ALABEL;
          nxt.skip  = {8'h00, data_byte};
        end
      end
      PH_ALABEL: begin
        nxt.skip = skip_dec;
        if (skip_dec == 16'd0) nxt.phase = PH_ANAME;
      end
      PH_APTR: begin
        nxt.phase = PH_RHDR;
        nxt.skip  = RR_FIXED_LEN;
      end
      PH_RHDR: begin
        // skip counts 10 down to 1: type at 10/9, data length at 2/1
        if (st.skip == 16'd10) nxt.rtype = {data_byte, 8'h00};
        else if (st.skip == 16'd9) nxt.rtype = {st.rtype[15:8], data_byte};
        else if (st.skip == 16'd2) nxt.rlen_hi = data_byte;
        nxt.skip = skip_dec;
        if (skip_dec == 16'd0) begin
          if (st.rtype == TYPE_A && len_now == 16'd4) begin
            nxt.phase = PH_ADATA;
            nxt.skip  = 16'd4;
            nxt.addr  = '0;
          end else if (len_now == 16'd0) begin
            nxt.ans_done = done_inc;
            nxt.phase    = (done_inc >= st.ans_total) ? PH_DONE : PH_ANAME;
          end else begin
            nxt.phase = PH_RDATA;
            nxt.skip  = len_now;
          end
        end
      end
      PH_ADATA: begin
        nxt.addr = {st.addr[23:0], data_byte};
        nxt.skip = skip_dec;
        if (skip_dec == 16'd0) begin
          nxt.found = 1'b1;
          nxt.phase = PH_DONE;
        end
      end
      PH_RDATA: begin
        nxt.skip = skip_dec;
        if (skip_dec == 16'd0) begin
          nxt.ans_done = done_inc;
          nxt.phase    = (done_inc >= st.ans_total) ? PH_DONE : PH_ANAME;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    address = 32'd0;
    priority if (st.offset < 4'd11 || !nxt.qr) begin
      status = ST_IGNORED;
    end else if (nxt.rcode_nz) begin
      status = ST_SRVERR;
    end else if (nxt.ans_total == 16'd0) begin
      status = ST_NOANS;
    end else if (nxt.found) begin
      status  = ST_RESOLVED;
      address = nxt.addr;
    end else begin
      status = ST_NOADDR;
    end
  end

endmodule

// File: design/dns_response_address_parser_core.sv
// Top level: DNS reply parser, input register, parser state and result register.
// Path: a last byte goes through the input register, then its result is held in the result register.
// Throughput: one byte per cycle; the input stage stalls only when a result is
// waiting and the byte in the input register is a last byte.
// Reset (synchronous, rst_n low) empties both stages and puts the parser in the
// header phase; the parser also returns there after every last byte.
module dns_response_address_parser_core (
  input logic        clk,
  input logic        rst_n,
  dnsrp_in_if.sink   in_ch,
  dnsrp_out_if.source out_ch
);
  import dnsrp_pkg::*;

  logic        in_vld_r;
  logic [7:0]  byte_r;
  logic        last_r;
  st_t         st_r;
  st_t         st_nxt;
  logic [2:0]  status_nxt;
  logic [31:0] address_nxt;
  logic        out_vld_r;
  logic [2:0]  status_r;
  logic [31:0] address_r;
  logic        adv;

  dnsrp_parse u_parse (
    .st        (st_r),
    .data_byte (byte_r),
    .nxt       (st_nxt),
    .status    (status_nxt),
    .address   (address_nxt)
  );

  assign adv         = in_vld_r && (!last_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.data_byte;
      last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= last_r ? '0 : st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_r) begin
      status_r  <= status_nxt;
      address_r <= address_nxt;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.status  = status_r;
  assign out_ch.address = address_r;

`ifndef SYNTHESIS
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && status_r != ST_RESOLVED |-> address_r == 32'd0)
    else $error("address nonzero without resolved status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> status_r <= ST_NOADDR)
    else $error("status code out of range");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv && last_r |=> st_r.phase == PH_HEADER && st_r.offset == 4'd0)
    else $error("parser not cleared after last byte");

  a_label_skip: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_QLABEL || st_r.phase == PH_ALABEL |-> st_r.skip != 16'd0)
    else $error("label phase with nothing left to skip");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(status_r) && $stable(address_r))
    else $error("pending result overwritten");
`endif

endmodule

// File: tb/tb_dns_response_address_parser_core.sv
// Testbench: DNS reply parser driven with generated replies and checked against a built-in predictor.
module tb_dns_response_address_parser_core;
  import dnsrp_pkg::*;

  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 300;
  localparam int PHASE_REPLIES = 4;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] address;
  } dns_result_t;

  class dns_reply_scoreboard;
    int          errors;
    dns_result_t expected_q[$];
    logic [15:0] offset;
    logic [3:0]  cur_phase;
    logic [15:0] flags;
    logic [15:0] an_total;
    logic [15:0] an_done;
    logic [15:0] skip_left;
    logic [15:0] rr_type;
    logic [15:0] rr_len;
    logic [31:0] addr_acc;
    logic        addr_found;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      offset     = '0;
      cur_phase  = PH_HEADER;
      flags      = '0;
      an_total   = '0;
      an_done    = '0;
      skip_left  = '0;
      rr_type    = '0;
      rr_len     = '0;
      addr_acc   = '0;
      addr_found = 1'b0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void start_rr_header();
      cur_phase = PH_RHDR;
      skip_left = RR_FIXED_LEN;
      rr_type   = '0;
      rr_len    = '0;
    endfunction

    function void end_record();
      an_done   = an_done + 16'd1;
      cur_phase = (an_done >= an_total) ? PH_DONE : PH_ANAME;
    endfunction

    function void parse_byte(logic [7:0] b);
      logic [15:0] idx;
      case (cur_phase)
        PH_HEADER: begin
          if (offset == 16'd2) flags = {b, 8'h00};
          else if (offset == 16'd3) flags[7:0] = b;
          else if (offset == 16'd6) an_total = {b, 8'h00};
          else if (offset == 16'd7) an_total[7:0] = b;
          else if (offset == 16'd11) begin
            if (!flags[15] || flags[3:0] != 4'h0 || an_total == 16'd0) cur_phase = PH_DONE;
            else cur_phase = PH_QNAME;
          end
        end
        PH_QNAME: begin
          if (b == 8'h00) begin
            cur_phase = PH_QTAIL;
            skip_left = 16'd4;
          end else if ((b & PTR_MASK) == PTR_MASK) begin
            cur_phase = PH_QTAIL;
            skip_left = 16'd5;
          end else begin
            cur_phase = PH_QLABEL;
            skip_left = {8'h00, b};
          end
        end
        PH_QLABEL: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) cur_phase = PH_QNAME;
        end
        PH_QTAIL: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) cur_phase = PH_ANAME;
        end
        PH_ANAME: begin
          if (b == 8'h00) start_rr_header();
          else if ((b & PTR_MASK) == PTR_MASK) cur_phase = PH_APTR;
          else begin
            cur_phase = PH_ALABEL;
            skip_left = {8'h00, b};
          end
        end
        PH_ALABEL: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) cur_phase = PH_ANAME;
        end
        PH_APTR: start_rr_header();
        PH_RHDR: begin
          idx = RR_FIXED_LEN - skip_left;
          if (idx == 16'd0) rr_type = {b, 8'h00};
          else if (idx == 16'd1) rr_type[7:0] = b;
          else if (idx == 16'd8) rr_len = {b, 8'h00};
          else if (idx == 16'd9) rr_len[7:0] = b;
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) begin
            if (rr_type == TYPE_A && rr_len == 16'd4) begin
              cur_phase = PH_ADATA;
              skip_left = 16'd4;
              addr_acc  = '0;
            end else if (rr_len == 16'd0) begin
              end_record();
            end else begin
              cur_phase = PH_RDATA;
              skip_left = rr_len;
            end
          end
        end
        PH_ADATA: begin
          addr_acc  = {addr_acc[23:0], b};
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) begin
            addr_found = 1'b1;
            cur_phase  = PH_DONE;
          end
        end
        PH_RDATA: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 16'd0) end_record();
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
      int          total;
      dns_result_t res;
      parse_byte(b);
      total = int'(offset) + 1;
      if (offset != 16'hFFFF) offset = offset + 16'd1;
      if (is_last) begin
        res.address = '0;
        if (total < 12 || !flags[15]) res.status = ST_IGNORED;
        else if (flags[3:0] != 4'h0) res.status = ST_SRVERR;
        else if (an_total == 16'd0) res.status = ST_NOANS;
        else if (addr_found) begin
          res.status  = ST_RESOLVED;
          res.address = addr_acc;
        end else res.status = ST_NOADDR;
        expected_q.push_back(res);
        clear();
      end
    endfunction

    task check_result(logic [2:0] status, logic [31:0] address);
      dns_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("result status %0d addr %h with none expected", status, address));
      end else begin
        exp_res = expected_q.pop_front();
        if (status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", status, exp_res.status));
        if (address !== exp_res.address)
          report($sformatf("address %h, expected %h", address, exp_res.address));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;
  int   idle_by_phase[4] = '{0, 81, 0, 10};
  int   stall_by_phase[4] = '{0, 0, 81, 10};
  logic [7:0] msg[$];
  dns_reply_scoreboard sb;

  dnsrp_in_if  in_ch();
  dnsrp_out_if out_ch();

  dns_response_address_parser_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.status, out_ch.address);
    end
  end

  task automatic send_byte(logic [7:0] b, logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_reply();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // labels, sometimes with non-pointer top bits, ended by a root byte or a pointer
  task automatic push_name();
    int len;
    repeat ($urandom_range(0, 2)) begin
      if ($urandom_range(0, 99) < 3) len = $urandom_range(8'h40, 8'hBF);
      else len = $urandom_range(1, 6);
      msg.push_back(len[7:0]);
      repeat (len) msg.push_back(8'($urandom));
    end
    if ($urandom_range(0, 99) < 35) begin
      msg.push_back(8'hC0 | 8'($urandom_range(0, 63)));
      msg.push_back(8'($urandom));
    end else begin
      msg.push_back(8'h00);
    end
  endtask

  task automatic make_reply();
    int          kind;
    int          sel;
    int          rdlen;
    int          cut;
    logic [15:0] an;
    logic [7:0]  fl_hi;
    logic [7:0]  fl_lo;
    logic        is_a;
    msg.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 11)) msg.push_back(8'($urandom));
      return;
    end
    fl_hi = 8'($urandom);
    fl_lo = 8'($urandom);
    if (kind >= 12) fl_hi[7] = 1'b1;
    if ($urandom_range(0, 99) >= 12) fl_lo[3:0] = 4'h0;
    sel = $urandom_range(0, 99);
    if (sel < 6) an = 16'd0;
    else if (sel < 10) an = 16'($urandom);
    else an = 16'($urandom_range(1, 3));
    repeat (2) msg.push_back(8'($urandom));
    msg.push_back(fl_hi);
    msg.push_back(fl_lo);
    repeat (2) msg.push_back(8'($urandom));
    msg.push_back(an[15:8]);
    msg.push_back(an[7:0]);
    repeat (4) msg.push_back(8'($urandom));
    push_name();
    repeat (4) msg.push_back(8'($urandom));
    repeat ((an > 16'd3) ? 3 : int'(an)) begin
      push_name();
      is_a = ($urandom_range(0, 99) < 60);
      if (is_a) begin
        msg.push_back(8'h00);
        msg.push_back(8'h01);
        rdlen = ($urandom_range(0, 99) < 80) ? 4 : $urandom_range(0, 6);
      end else begin
        repeat (2) msg.push_back(8'($urandom));
        rdlen = $urandom_range(0, 8);
      end
      repeat (6) msg.push_back(8'($urandom));
      msg.push_back(8'h00);
      msg.push_back(rdlen[7:0]);
      repeat (rdlen) msg.push_back(8'($urandom));
    end
    if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom));
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, msg.size());
      while (msg.size() > cut) void'(msg.pop_back());
    end
  endtask

  initial begin
    int phase_bytes;
    int replies;
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.last_byte <= 1'b0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      if (ph == 0) begin
        // one-byte reply, then a resolved reply with a pointer question and a label+pointer answer
        msg = '{8'hFF};
        send_reply();
        msg = '{8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                8'h00, 8'h00, 8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h01, 8'h78,
                8'hC0, 8'h10, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h3C,
                8'h00, 8'h04, 8'hFF, 8'h00, 8'hA5, 8'h5A};
        send_reply();
      end
      phase_bytes = 0;
      replies = 0;
      while (phase_bytes < PHASE_BYTES || replies < PHASE_REPLIES) begin
        make_reply();
        send_reply();
        phase_bytes += msg.size();
        replies++;
      end
      wait_drained();
      if (ph == 0) begin
        // receiver held off while one-byte replies keep coming: input must back up
        hold_req <= hold_req + 1;
        repeat (40) begin
          msg = '{8'($urandom)};
          send_reply();
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
